>>> rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types for the nearest-two prototype search: the tag that travels
// with each distance through the datapath and the controller command group.
// ----------------------------------------------------------------------------
package nps_pkg;

	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// register index within the APB window
	localparam logic REG_ACTIVE_COUNT = 1'b0;

	// role of a distance in the candidate scan
	typedef enum logic [1:0] {
		TAG_BEST_INIT,
		TAG_SEC_INIT,
		TAG_CMP
	} nps_tag_t;

	typedef struct packed {
		logic     wr_en;     // write prototype from input ports
		logic     capture;   // latch query event
		logic     issue;     // start one distance read
		nps_tag_t tag;
		logic     load_out;  // load result register
		logic     out_query; // result is a query answer
	} nps_cmd_t;

endpackage

>>> rtl/nearest_two_prototype_search.sv
// ----------------------------------------------------------------------------
// nearest_two_prototype_search
// Two-nearest search over a table of 4-D prototypes (x, y, z, time).
// Load beats write one prototype; query beats return the nearest and
// second-nearest slot with squared distance dx^2+dy^2+dz^2+4*dt^2.
//
//   channel  direction  handshake             payload
//   in       in         in_valid / in_stall   action slot coord_x..phase_time
//   out      out        out_valid / out_stall is_query_result best/second_*
//   cfg      in/out     APB (psel..pready)    active_count at byte 0
//
// A load beat passes the done state and the result load; a query beat
// first does n+1 memory reads, one read per cycle, n being the clamped
// active count, then passes the 3-stage distance pipeline, a drain check
// and the result load. The input stalls while a beat is in work, longer
// while a result waits on out_stall. One beat is in work at a time; a new
// beat is taken while the last result still waits on out_stall. Reset
// leaves active_count at 2; the prototype memory holds no defined value
// until loaded.
// ----------------------------------------------------------------------------
module nearest_two_prototype_search #(
	parameter int unsigned MAX_PROTOTYPES = 64,
	parameter int unsigned COORD_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [$clog2(MAX_PROTOTYPES)-1:0] slot,
	input  logic [COORD_BITS-1:0]             coord_x,
	input  logic [COORD_BITS-1:0]             coord_y,
	input  logic [COORD_BITS-1:0]             coord_z,
	input  logic [COORD_BITS-1:0]             phase_time,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              is_query_result,
	output logic [$clog2(MAX_PROTOTYPES)-1:0] best_slot,
	output logic [$clog2(MAX_PROTOTYPES)-1:0] second_slot,
	output logic [2*COORD_BITS+2:0]           best_distance,
	output logic [2*COORD_BITS+2:0]           second_distance,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nps_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [nps_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [nps_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	nps_pkg::nps_cmd_t                 cmd;
	logic                              pipe_busy;
	logic [$clog2(MAX_PROTOTYPES)-1:0] rd_addr;

	assign pready = 1'b1;

	nps_ctrl #(
		.MAX_PROTOTYPES(MAX_PROTOTYPES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pipe_busy (pipe_busy),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	nps_dpath #(
		.MAX_PROTOTYPES(MAX_PROTOTYPES),
		.COORD_BITS    (COORD_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.pipe_busy       (pipe_busy),
		.slot            (slot),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.phase_time      (phase_time),
		.is_query_result (is_query_result),
		.best_slot       (best_slot),
		.second_slot     (second_slot),
		.best_distance   (best_distance),
		.second_distance (second_distance)
	);

endmodule

>>> rtl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: active count register, item sequencing, read address stream
// and output valid.
// ----------------------------------------------------------------------------
module nps_ctrl #(
	parameter int unsigned MAX_PROTOTYPES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [nps_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [nps_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [nps_pkg::APB_DATA_W-1:0]        prdata,
	input  logic                                  pipe_busy,
	output nps_pkg::nps_cmd_t                     cmd,
	output logic [$clog2(MAX_PROTOTYPES)-1:0]     rd_addr
);

	localparam int unsigned SLOT_W = $clog2(MAX_PROTOTYPES);
	localparam int unsigned CNT_W  = $clog2(MAX_PROTOTYPES + 1);
	localparam int unsigned APB_ADDR_W_IDX = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] step_q;
	logic             query_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] n_eff;
	logic             accept;
	logic             reg_wr;
	logic             out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign reg_wr   = psel && penable && pwrite &&
	                  (paddr[APB_ADDR_W_IDX] == nps_pkg::REG_ACTIVE_COUNT);

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W_IDX] == nps_pkg::REG_ACTIVE_COUNT) begin
			prdata[CNT_W-1:0] = count_q;
		end
	end

	// zero counts as one, anything past the table saturates
	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_PROTOTYPES)) begin
			n_eff = CNT_W'(MAX_PROTOTYPES);
		end else begin
			n_eff = count_q;
		end
	end

	// scan order: slot 0, last active slot, then slots 1 .. n-1
	always_comb begin
		if (step_q == '0) begin
			rd_addr = '0;
		end else if (step_q == CNT_W'(1)) begin
			rd_addr = SLOT_W'(n_eff - CNT_W'(1));
		end else begin
			rd_addr = SLOT_W'(step_q - CNT_W'(1));
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.wr_en     = accept && !action;
		cmd.capture   = accept && action;
		cmd.issue     = (state_q == ST_ISSUE);
		cmd.out_query = query_q;
		cmd.load_out  = (state_q == ST_DONE) && out_free;
		if (step_q == '0) begin
			cmd.tag = nps_pkg::TAG_BEST_INIT;
		end else if (step_q == CNT_W'(1)) begin
			cmd.tag = nps_pkg::TAG_SEC_INIT;
		end else begin
			cmd.tag = nps_pkg::TAG_CMP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= CNT_W'(2);
			step_q      <= '0;
			query_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (reg_wr) begin
				count_q <= pwdata[CNT_W-1:0];
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept) begin
						query_q <= action;
						state_q <= action ? ST_ISSUE : ST_DONE;
					end
				end
				ST_ISSUE: begin
					if (step_q == n_eff) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/nps_dpath.sv
// ----------------------------------------------------------------------------
// nps_dpath
// Datapath: prototype memory, distance pipeline (read, square, sum) and the
// best/second candidate registers feeding the result register.
// ----------------------------------------------------------------------------
module nps_dpath #(
	parameter int unsigned MAX_PROTOTYPES = 64,
	parameter int unsigned COORD_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nps_pkg::nps_cmd_t                 cmd,
	input  logic [$clog2(MAX_PROTOTYPES)-1:0] rd_addr,
	output logic                              pipe_busy,
	input  logic [$clog2(MAX_PROTOTYPES)-1:0] slot,
	input  logic [COORD_BITS-1:0]             coord_x,
	input  logic [COORD_BITS-1:0]             coord_y,
	input  logic [COORD_BITS-1:0]             coord_z,
	input  logic [COORD_BITS-1:0]             phase_time,
	output logic                              is_query_result,
	output logic [$clog2(MAX_PROTOTYPES)-1:0] best_slot,
	output logic [$clog2(MAX_PROTOTYPES)-1:0] second_slot,
	output logic [2*COORD_BITS+2:0]           best_distance,
	output logic [2*COORD_BITS+2:0]           second_distance
);

	localparam int unsigned SLOT_W = $clog2(MAX_PROTOTYPES);
	localparam int unsigned CB     = COORD_BITS;
	localparam int unsigned SQ_W   = 2 * CB;
	localparam int unsigned DIST_W = 2 * CB + 3;
	localparam int unsigned ENT_W  = 4 * CB;

	logic [ENT_W-1:0] mem [MAX_PROTOTYPES];

	logic [CB-1:0]     ev_x_q, ev_y_q, ev_z_q, ev_t_q;
	logic [ENT_W-1:0]  ent_s1;
	logic              v_s1, v_s2, v_s3;
	nps_pkg::nps_tag_t tag_s1, tag_s2, tag_s3;
	logic [SLOT_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2, sqz_s2, sqt_s2;
	logic [DIST_W-1:0] dist_s3;
	logic [SLOT_W-1:0] best_q, sec_q;
	logic [DIST_W-1:0] dbest_q, dsec_q;
	logic [CB-1:0]     dx, dy, dz, dt;
	logic [CB-1:0]     px, py, pz, pt;
	logic              slot_ok;

	assign slot_ok   = ({1'b0, slot} < (SLOT_W + 1)'(MAX_PROTOTYPES));
	assign pipe_busy = v_s1 || v_s2 || v_s3;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && slot_ok) begin
			mem[slot] <= {coord_x, coord_y, coord_z, phase_time};
		end
		ent_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ev_x_q <= coord_x;
			ev_y_q <= coord_y;
			ev_z_q <= coord_z;
			ev_t_q <= phase_time;
		end
	end

	assign {px, py, pz, pt} = ent_s1;
	assign dx = (ev_x_q >= px) ? ev_x_q - px : px - ev_x_q;
	assign dy = (ev_y_q >= py) ? ev_y_q - py : py - ev_y_q;
	assign dz = (ev_z_q >= pz) ? ev_z_q - pz : pz - ev_z_q;
	assign dt = (ev_t_q >= pt) ? ev_t_q - pt : pt - ev_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= cmd.tag;
		idx_s1  <= rd_addr;
		tag_s2  <= tag_s1;
		idx_s2  <= idx_s1;
		sqx_s2  <= SQ_W'(dx) * SQ_W'(dx);
		sqy_s2  <= SQ_W'(dy) * SQ_W'(dy);
		sqz_s2  <= SQ_W'(dz) * SQ_W'(dz);
		sqt_s2  <= SQ_W'(dt) * SQ_W'(dt);
		tag_s3  <= tag_s2;
		idx_s3  <= idx_s2;
		// time term is weighted by four
		dist_s3 <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2)
		         + DIST_W'({sqt_s2, 2'b00});
	end

	// ties keep the earlier candidate
	always_ff @(posedge clk) begin
		if (v_s3) begin
			case (tag_s3)
				nps_pkg::TAG_BEST_INIT: begin
					best_q  <= idx_s3;
					dbest_q <= dist_s3;
				end
				nps_pkg::TAG_SEC_INIT: begin
					sec_q  <= idx_s3;
					dsec_q <= dist_s3;
				end
				default: begin
					if (dist_s3 < dbest_q) begin
						sec_q   <= best_q;
						dsec_q  <= dbest_q;
						best_q  <= idx_s3;
						dbest_q <= dist_s3;
					end else if (dist_s3 < dsec_q && best_q != idx_s3) begin
						sec_q  <= idx_s3;
						dsec_q <= dist_s3;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			is_query_result <= cmd.out_query;
			if (cmd.out_query) begin
				best_slot       <= best_q;
				second_slot     <= sec_q;
				best_distance   <= dbest_q;
				second_distance <= dsec_q;
			end else begin
				best_slot       <= '0;
				second_slot     <= '0;
				best_distance   <= '0;
				second_distance <= '0;
			end
		end
	end

endmodule

>>> tb/tb_nearest_two_prototype_search.sv
// ----------------------------------------------------------------------------
// tb_nearest_two_prototype_search
// Self-checking bench for the nearest-two prototype search. Loads and queries
// are pushed through the input channel with random gaps while the output side
// stalls at random. Each query answer is predicted from a local copy of the
// prototype table and the active count. Directed cases cover the field
// extremes, ties, a single active slot and the register decode. Random phases
// then run under several active counts, including saturated ones.
// ----------------------------------------------------------------------------
module tb_nearest_two_prototype_search;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned APB_ADDR_W = nps_pkg::APB_ADDR_W;
	localparam int unsigned APB_DATA_W = nps_pkg::APB_DATA_W;

	localparam int NPROTO = 64;
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;
	localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_COUNT = {nps_pkg::REG_ACTIVE_COUNT, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_NO_REG       = 3'd4;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [15:0] t;
	} point_t;

	typedef struct packed {
		logic        is_query;
		logic [5:0]  best_slot;
		logic [5:0]  second_slot;
		logic [34:0] best_dist;
		logic [34:0] second_dist;
	} answer_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  action = 1'b0;
	logic [5:0]            slot = '0;
	logic [15:0]           coord_x = '0;
	logic [15:0]           coord_y = '0;
	logic [15:0]           coord_z = '0;
	logic [15:0]           phase_time = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  is_query_result;
	logic [5:0]            best_slot;
	logic [5:0]            second_slot;
	logic [34:0]           best_distance;
	logic [34:0]           second_distance;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// local copy of the block state
	point_t          proto_table[NPROTO];
	logic [NPROTO-1:0] loaded = '0;
	logic [6:0]      count_reg = 7'd2;
	answer_t         search_answers[$];
	int              err_count = 0;
	int              stall_left = 0;

	nearest_two_prototype_search u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.slot            (slot),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.phase_time      (phase_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.is_query_result (is_query_result),
		.best_slot       (best_slot),
		.second_slot     (second_slot),
		.best_distance   (best_distance),
		.second_distance (second_distance),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [34:0] sq_dist(point_t p, point_t e);
		logic [15:0] dx, dy, dz, dt;
		dx = (e.x >= p.x) ? e.x - p.x : p.x - e.x;
		dy = (e.y >= p.y) ? e.y - p.y : p.y - e.y;
		dz = (e.z >= p.z) ? e.z - p.z : p.z - e.z;
		dt = (e.t >= p.t) ? e.t - p.t : p.t - e.t;
		return 35'(dx) * 35'(dx) + 35'(dy) * 35'(dy) + 35'(dz) * 35'(dz)
			+ 35'd4 * 35'(dt) * 35'(dt);
	endfunction

	function automatic int active_n();
		if (count_reg == 0)
			return 1;
		if (count_reg > NPROTO)
			return NPROTO;
		return int'(count_reg);
	endfunction

	// scan from slot 0; best seeded with slot 0, second with the last active slot
	function automatic answer_t nearest_two(point_t ev);
		answer_t     a;
		int          n, b, s;
		logic [34:0] db, ds, d;
		n = active_n();
		b = 0;
		s = n - 1;
		db = sq_dist(proto_table[b], ev);
		ds = sq_dist(proto_table[s], ev);
		for (int i = 0; i < n; i++) begin
			d = sq_dist(proto_table[i], ev);
			if (d < db) begin
				s = b;
				ds = db;
				b = i;
				db = d;
			end else if (d < ds && b != i) begin
				s = i;
				ds = d;
			end
		end
		a.is_query = 1'b1;
		a.best_slot = 6'(b);
		a.second_slot = 6'(s);
		a.best_dist = db;
		a.second_dist = ds;
		return a;
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(1 << $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic point_t pick_point();
		point_t p;
		p.x = pick_coord();
		p.y = pick_coord();
		p.z = pick_coord();
		p.t = pick_coord();
		return p;
	endfunction

	// small offset around a prototype gives close races for best and second
	function automatic point_t near_point(point_t p);
		point_t q;
		q.x = p.x ^ 16'($urandom_range(0, 3));
		q.y = p.y ^ 16'($urandom_range(0, 3));
		q.z = p.z ^ 16'($urandom_range(0, 3));
		q.t = p.t ^ 16'($urandom_range(0, 1));
		return q;
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(string name, logic [34:0] want, logic [34:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	// one input beat; valid stays high into the next beat when gap is zero
	task automatic send_beat(logic act, logic [5:0] sl, point_t v, int gap);
		answer_t a;
		in_valid <= 1'b1;
		action <= act;
		slot <= sl;
		coord_x <= v.x;
		coord_y <= v.y;
		coord_z <= v.z;
		phase_time <= v.t;
		do @(posedge clk); while (in_stall);
		if (act == ACT_LOAD) begin
			proto_table[sl] = v;
			loaded[sl] = 1'b1;
			a = '0;
		end else begin
			a = nearest_two(v);
		end
		search_answers.insert(search_answers.size(), a);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (search_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_ACTIVE_COUNT)
			count_reg = data[6:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check_read();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_ACTIVE_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(count_reg)) begin
			$display("%0t ns: active_count read mismatch, expected %0d, actual %0d",
				$time, count_reg, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// output side: free runs and stall bursts picked at random, mostly short
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left == 0) begin
			if ($urandom_range(0, 1)) begin
				out_stall <= 1'b0;
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 20);
			end else begin
				out_stall <= 1'b1;
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
					: $urandom_range(1, 3);
			end
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (search_answers.size() == 0) begin
				$display("%0t ns: result beat with nothing pending, expected none, actual %0d",
					$time, is_query_result);
				err_count++;
			end else begin
				want = search_answers.pop_front();
				check_field("is_query_result", 35'(want.is_query), 35'(is_query_result));
				check_field("best_slot", 35'(want.best_slot), 35'(best_slot));
				check_field("second_slot", 35'(want.second_slot), 35'(second_slot));
				check_field("best_distance", want.best_dist, best_distance);
				check_field("second_distance", want.second_dist, second_distance);
			end
		end
	end

	task automatic test_reset_value();
		apb_check_read();
	endtask

	task automatic test_two_slot_extremes();
		point_t lo, hi, mix;
		lo = '0;
		hi = '1;
		send_beat(ACT_LOAD, 6'd0, lo, 0);
		send_beat(ACT_LOAD, 6'd1, hi, 1);
		send_beat(ACT_QUERY, 6'h3F, lo, 0);
		send_beat(ACT_QUERY, 6'd0, hi, 2);
		mix.x = 16'hFFFF;
		mix.y = 16'h0000;
		mix.z = 16'h8000;
		mix.t = 16'h7FFF;
		send_beat(ACT_QUERY, 6'd5, mix, 0);
		// equidistant event: x=1 between prototypes at x=0 and x=2
		mix = '0;
		mix.x = 16'd2;
		send_beat(ACT_LOAD, 6'd1, mix, 0);
		mix.x = 16'd1;
		send_beat(ACT_QUERY, 6'd0, mix, 0);
		settle();
	endtask

	task automatic test_single_slot();
		apb_write(ADDR_ACTIVE_COUNT, 32'd1);
		apb_check_read();
		send_beat(ACT_QUERY, 6'd0, pick_point(), 0);
		send_beat(ACT_QUERY, 6'd0, '1, 1);
		settle();
		// zero count behaves as one slot
		apb_write(ADDR_ACTIVE_COUNT, 32'd0);
		apb_check_read();
		send_beat(ACT_QUERY, 6'd9, pick_point(), 0);
		settle();
	endtask

	task automatic test_config_decode();
		apb_write(ADDR_NO_REG, 32'd5);
		apb_check_read();
		// bits above the register width are dropped
		apb_write(ADDR_ACTIVE_COUNT, 32'hFFFF_FF84);
		apb_check_read();
	endtask

	task automatic test_equal_distances();
		send_beat(ACT_LOAD, 6'd1, '0, 0);
		send_beat(ACT_LOAD, 6'd2, '0, 0);
		send_beat(ACT_LOAD, 6'd3, '0, 0);
		send_beat(ACT_QUERY, 6'd0, '0, 0);
		send_beat(ACT_QUERY, 6'd0, '1, 3);
		send_beat(ACT_LOAD, 6'd3, '1, 0);
		send_beat(ACT_QUERY, 6'd0, '1, 0);
		send_beat(ACT_QUERY, 6'd0, near_point('0), 0);
		settle();
	endtask

	task automatic test_random_traffic(logic [31:0] cfg_word, int beats, bit back_to_back);
		int          n, gap, sl;
		logic [63:0] need_mask;
		point_t      v;
		apb_write(ADDR_ACTIVE_COUNT, cfg_word);
		apb_check_read();
		repeat (beats) begin
			n = active_n();
			need_mask = (n == NPROTO) ? '1 : ((64'd1 << n) - 64'd1);
			gap = back_to_back ? 0 : rand_gap();
			if ((loaded & need_mask) != need_mask) begin
				// fill the active range before any query may read it
				sl = 0;
				for (int i = n - 1; i >= 0; i--)
					if (!loaded[i])
						sl = i;
				send_beat(ACT_LOAD, 6'(sl), pick_point(), gap);
			end else if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 3))
					0: v = near_point(proto_table[$urandom_range(0, n - 1)]);
					1: v = proto_table[$urandom_range(0, n - 1)];
					default: v = pick_point();
				endcase
				send_beat(ACT_QUERY, 6'($urandom), v, gap);
			end else begin
				sl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NPROTO - 1)
					: $urandom_range(0, n - 1);
				v = ($urandom_range(0, 4) == 0) ? proto_table[$urandom_range(0, n - 1)]
					: pick_point();
				send_beat(ACT_LOAD, 6'(sl), v, gap);
			end
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_value();
		test_two_slot_extremes();
		test_single_slot();
		test_config_decode();
		test_equal_distances();
		test_random_traffic(32'd64, 90, 1'b0);
		test_random_traffic(32'd127, 70, 1'b0);
		test_random_traffic(32'd65, 60, 1'b1);
		test_random_traffic(32'd3, 70, 1'b0);
		test_random_traffic(32'd1, 40, 1'b0);
		test_random_traffic(32'($urandom_range(1, 64)), 80, 1'b0);
		test_random_traffic(32'd0, 40, 1'b1);
		test_random_traffic(32'($urandom), 80, 1'b0);
		test_random_traffic(32'd2, 50, 1'b0);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
